// File: rtl/rpfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpfp_pkg;

    // Framebuffer depth codes held in the depth_mode register.
    typedef enum logic [1:0] {
        MODE_BGRX   = 2'd0,
        MODE_BGR    = 2'd1,
        MODE_PACKED = 2'd2,
        MODE_LUMA   = 2'd3
    } depth_mode_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEPTH_MODE = 3'd0;
    localparam logic [2:0] CFG_RED_SIZE   = 3'd1;
    localparam logic [2:0] CFG_RED_POS    = 3'd2;
    localparam logic [2:0] CFG_GREEN_SIZE = 3'd3;
    localparam logic [2:0] CFG_GREEN_POS  = 3'd4;
    localparam logic [2:0] CFG_BLUE_SIZE  = 3'd5;
    localparam logic [2:0] CFG_BLUE_POS   = 3'd6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 4;

    // Luma weights.
    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd150;
    localparam logic [15:0] LUMA_B = 16'd29;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    // One classified pixel: its bytes in output order, the index of its
    // last byte and the span flag.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            span_end;
    } pix_entry_t;

endpackage

`default_nettype wire

// File: rtl/rpfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfp_front
    import rpfp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           pixel,
    input  wire logic                  span_end,
    input  wire logic                  queue_full,
    output logic                       push,
    output pix_entry_t                 push_entry
);

    depth_mode_t depth_mode_reg, depth_mode_next;
    logic [3:0]  red_size_reg, red_size_next;
    logic [3:0]  red_pos_reg, red_pos_next;
    logic [3:0]  green_size_reg, green_size_next;
    logic [3:0]  green_pos_reg, green_pos_next;
    logic [3:0]  blue_size_reg, blue_size_next;
    logic [3:0]  blue_pos_reg, blue_pos_next;

    logic [7:0]  red, green, blue;
    logic [15:0] packed_word;
    logic [15:0] luma_sum;

    // Keeps the top size bits of a channel and moves them to pos.
    function automatic logic [15:0] place_channel(input logic [7:0] ch,
                                                  input logic [3:0] size,
                                                  input logic [3:0] pos);
        logic [3:0]  kept_bits;
        logic [7:0]  kept;
        logic [15:0] wide;
        kept_bits = (size > 4'd8) ? 4'd8 : size;
        kept      = ch >> (4'd8 - kept_bits);
        wide      = {8'h00, kept} << pos;
        return wide;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        depth_mode_next = depth_mode_reg;
        red_size_next   = red_size_reg;
        red_pos_next    = red_pos_reg;
        green_size_next = green_size_reg;
        green_pos_next  = green_pos_reg;
        blue_size_next  = blue_size_reg;
        blue_pos_next   = blue_pos_reg;
        if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_DEPTH_MODE: depth_mode_next = depth_mode_t'(cfg_data[1:0]);
                CFG_RED_SIZE:   red_size_next   = cfg_data;
                CFG_RED_POS:    red_pos_next    = cfg_data;
                CFG_GREEN_SIZE: green_size_next = cfg_data;
                CFG_GREEN_POS:  green_pos_next  = cfg_data;
                CFG_BLUE_SIZE:  blue_size_next  = cfg_data;
                CFG_BLUE_POS:   blue_pos_next   = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= MODE_BGRX;
            red_size_reg   <= 4'd5;
            red_pos_reg    <= 4'd11;
            green_size_reg <= 4'd6;
            green_pos_reg  <= 4'd5;
            blue_size_reg  <= 4'd5;
            blue_pos_reg   <= 4'd0;
        end
        else
        begin
            depth_mode_reg <= depth_mode_next;
            red_size_reg   <= red_size_next;
            red_pos_reg    <= red_pos_next;
            green_size_reg <= green_size_next;
            green_pos_reg  <= green_pos_next;
            blue_size_reg  <= blue_size_next;
            blue_pos_reg   <= blue_pos_next;
        end
    end

    assign red   = pixel[23:16];
    assign green = pixel[15:8];
    assign blue  = pixel[7:0];

    assign packed_word = place_channel(red, red_size_reg, red_pos_reg)
                       | place_channel(green, green_size_reg, green_pos_reg)
                       | place_channel(blue, blue_size_reg, blue_pos_reg);

    // The weighted sum peaks at 255 * 256 and so fits in 16 bits.
    assign luma_sum = 16'({8'h00, red} * LUMA_R)
                    + 16'({8'h00, green} * LUMA_G)
                    + 16'({8'h00, blue} * LUMA_B);

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_entry.span_end = span_end;
        case (depth_mode_reg)
            MODE_BGRX:
            begin
                push_entry.bytes    = {8'h00, red, green, blue};
                push_entry.last_idx = 2'd3;
            end
            MODE_BGR:
            begin
                push_entry.bytes    = {8'h00, red, green, blue};
                push_entry.last_idx = 2'd2;
            end
            MODE_PACKED:
            begin
                push_entry.bytes    = {16'h0000, packed_word};
                push_entry.last_idx = 2'd1;
            end
            default:
            begin
                push_entry.bytes    = {24'h000000, luma_sum[15:8] & BYTE_MASK};
                push_entry.last_idx = 2'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rpfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfp_queue
    import rpfp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire pix_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output pix_entry_t      head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    pix_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// File: rtl/rpfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfp_back
    import rpfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire pix_entry_t head_entry,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            pixel_done,
    output logic            span_done
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       pixel_done_reg;
    logic       span_done_reg;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign at_last = (idx_reg == head_entry.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= head_entry.bytes[idx_reg];
            pixel_done_reg <= at_last;
            span_done_reg  <= at_last && head_entry.span_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign pixel_done = pixel_done_reg;
    assign span_done  = span_done_reg;

`ifndef ASSERT_OFF
    a_span_on_pixel_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && span_done_reg |-> pixel_done_reg)
        else $error("span end flagged on a byte that does not end a pixel");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg <= head_entry.last_idx)
        else $error("byte index ran past the last byte of the pixel");
`endif

endmodule

`default_nettype wire

// File: rtl/rgb_pixel_format_packer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Path: each accepted pixel word is written into the queue, and its bytes then leave through the
// byte-wide output register. Throughput: one output byte per cycle while out_ready stays high, so a
// pixel yields 4, 3, 2 or 1 bytes in 32-bit, 24-bit, packed and luma mode.
// Reset: configuration returns to 32-bit mode with a 5:6:5 layout, the queue empties and
// no output word is pending. There is no clearing pass.

module rgb_pixel_format_packer_core
    import rpfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           pixel,
    input  wire logic                  span_end,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic                       pixel_done,
    output logic                       span_done
);

    // The front converts each accepted pixel word into its full set of
    // framebuffer bytes in a single step and writes them to the queue.
    logic       push;
    pix_entry_t push_entry;
    logic       queue_full;

    // The back walks the head entry one byte per cycle, while out_ready is high, through its
    // output register and frees the entry when the last byte is loaded, so the front keeps
    // accepting words while the back is still draining, until the queue is full.
    logic       pop;
    logic       head_valid;
    pix_entry_t head_entry;

    rpfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .span_end   (span_end),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rpfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    rpfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .pixel_done (pixel_done),
        .span_done  (span_done)
    );

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the RGB pixel packer. Pixel words go in on a
// valid/ready channel, framebuffer bytes come back on another one, and a
// predictor inside the bench builds the expected byte stream from its own
// copy of the configuration registers.
module testbench;
    import rpfp_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int GAP_PERCENT   = 23;
    localparam int HOLD_CYCLES   = 150;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // One source pixel waiting to be offered to the block.
    typedef struct packed {
        logic [31:0] argb;
        logic        last_in_span;
    } src_pixel_t;

    // One framebuffer byte as the block should emit it.
    typedef struct packed {
        logic [7:0] data;
        logic       last_of_pixel;
        logic       last_of_span;
    } fb_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] pixel = '0;
    logic        span_end = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        pixel_done;
    logic        span_done;

    rgb_pixel_format_packer_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .span_end   (span_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .pixel_done (pixel_done),
        .span_done  (span_done)
    );

    // The bench's own copy of the configuration. Channel arrays are indexed
    // red, green, blue.
    depth_mode_t fb_mode = MODE_BGRX;
    logic [3:0]  chan_size [3] = '{4'd5, 4'd6, 4'd5};
    logic [3:0]  chan_pos  [3] = '{4'd11, 4'd5, 4'd0};

    src_pixel_t pending_pixels [$];
    fb_byte_t   fb_expect [$];

    int  pixels_queued = 0;
    int  pixels_taken = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    logic in_fire = 1'b0;

    // When set, neither side inserts random gaps.
    logic no_gaps = 1'b0;

    // Hold-off requests for the receiver: the stimulus bumps the order
    // count and the receiver process counts the stalled cycles itself.
    int stall_orders = 0;
    int stall_served = 0;
    int hold_left = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog. A healthy run finishes far below this bound.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Keeps the top bits of one channel and moves them to their place in
    // the 16-bit word. Sizes above eight keep the whole channel, size zero
    // keeps nothing, and anything pushed past bit 15 falls off the top.
    function automatic logic [15:0] place_field(logic [7:0] chan, logic [3:0] size,
                                                logic [3:0] pos);
        int unsigned keep;
        logic [31:0] kept;
        keep = (size > 4'd8) ? 8 : int'(size);
        kept = 32'(chan) >> (8 - keep);
        return 16'(kept << pos);
    endfunction

    function automatic void push_byte(logic [7:0] data, logic last, logic span_flag);
        fb_byte_t entry;
        entry.data          = data;
        entry.last_of_pixel = last;
        entry.last_of_span  = last && span_flag;
        fb_expect.push_back(entry);
    endfunction

    // Works out the byte stream of one accepted pixel under the current
    // configuration. Alpha never reaches the output.
    function automatic void predict_pixel_bytes(logic [31:0] argb, logic span_flag);
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] packed_word;
        logic [31:0] luma_sum;
        red   = argb[23:16];
        green = argb[15:8];
        blue  = argb[7:0];
        case (fb_mode)
            MODE_BGRX:
            begin
                push_byte(blue, 1'b0, span_flag);
                push_byte(green, 1'b0, span_flag);
                push_byte(red, 1'b0, span_flag);
                push_byte(8'h00, 1'b1, span_flag);
            end
            MODE_BGR:
            begin
                push_byte(blue, 1'b0, span_flag);
                push_byte(green, 1'b0, span_flag);
                push_byte(red, 1'b1, span_flag);
            end
            MODE_PACKED:
            begin
                // Overlapping fields simply OR into each other.
                packed_word = place_field(red, chan_size[0], chan_pos[0])
                            | place_field(green, chan_size[1], chan_pos[1])
                            | place_field(blue, chan_size[2], chan_pos[2]);
                push_byte(packed_word[7:0], 1'b0, span_flag);
                push_byte(packed_word[15:8], 1'b1, span_flag);
            end
            default:
            begin
                luma_sum = 32'(red) * 32'(LUMA_R) + 32'(green) * 32'(LUMA_G)
                         + 32'(blue) * 32'(LUMA_B);
                push_byte(8'(luma_sum >> 8), 1'b1, span_flag);
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, fb_byte_t want, fb_byte_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
            $display("  expected byte %02h done %b span %b, got byte %02h done %b span %b",
                     want.data, want.last_of_pixel, want.last_of_span,
                     got.data, got.last_of_pixel, got.last_of_span);
        end
    endfunction

    // Monitor. Everything is sampled on the rising edge. Output bytes are
    // checked before the pixel accepted on the same edge is predicted; since
    // every pixel passes through the queue and the output register, a byte can
    // never belong to a pixel taken on the same edge.
    always @(posedge clk)
    begin
        fb_byte_t got;
        fb_byte_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                got.data          = out_byte;
                got.last_of_pixel = pixel_done;
                got.last_of_span  = span_done;
                if (fb_expect.size() == 0)
                begin
                    note_mismatch("byte with nothing expected", '0, got);
                end
                else
                begin
                    want = fb_expect.pop_front();
                    if (got.data !== want.data)
                        note_mismatch("out_byte differs", want, got);
                    else if (got.last_of_pixel !== want.last_of_pixel)
                        note_mismatch("pixel_done differs", want, got);
                    else if (got.last_of_span !== want.last_of_span)
                        note_mismatch("span_done differs", want, got);
                end
            end
            if (in_valid && in_ready)
            begin
                predict_pixel_bytes(pixel, span_end);
                pixels_taken++;
            end
        end
    end

    // Pixel driver. It works on the falling edge: a word stays on the port
    // until the monitor has seen it taken, and only then may the next one
    // go out or a gap be inserted.
    always @(negedge clk)
    begin
        src_pixel_t next_pixel;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_pixels.size() != 0
                && (no_gaps || $urandom_range(0, 99) >= GAP_PERCENT))
            begin
                next_pixel = pending_pixels.pop_front();
                in_valid <= 1'b1;
                pixel    <= next_pixel.argb;
                span_end <= next_pixel.last_in_span;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. It either serves a long hold-off or takes bytes with random
    // gaps.
    always @(negedge clk)
    begin
        if (stall_orders != stall_served)
        begin
            hold_left = HOLD_CYCLES;
            stall_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    task automatic queue_pixel(logic [31:0] argb, logic last_in_span);
        src_pixel_t item;
        item.argb = argb;
        item.last_in_span = last_in_span;
        pending_pixels.push_back(item);
        pixels_queued++;
    endtask

    task automatic queue_random_pixels(int count);
        repeat (count)
            queue_pixel($urandom(), $urandom_range(0, 3) == 0);
    endtask

    // Waits until every queued pixel has been taken and every byte of it
    // has come back, then lets the output stage settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixels_taken != pixels_queued || fb_expect.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    // Register write. Only called while the block is idle, so the bench's
    // copy can change the moment the write is accepted.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (addr)
            CFG_DEPTH_MODE: fb_mode = depth_mode_t'(data[1:0]);
            CFG_RED_SIZE:   chan_size[0] = data;
            CFG_RED_POS:    chan_pos[0] = data;
            CFG_GREEN_SIZE: chan_size[1] = data;
            CFG_GREEN_POS:  chan_pos[1] = data;
            CFG_BLUE_SIZE:  chan_size[2] = data;
            CFG_BLUE_POS:   chan_pos[2] = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_layout(logic [3:0] rs, logic [3:0] rp, logic [3:0] gs,
                                logic [3:0] gp, logic [3:0] bs, logic [3:0] bp);
        write_reg(CFG_RED_SIZE, rs);
        write_reg(CFG_RED_POS, rp);
        write_reg(CFG_GREEN_SIZE, gs);
        write_reg(CFG_GREEN_POS, gp);
        write_reg(CFG_BLUE_SIZE, bs);
        write_reg(CFG_BLUE_POS, bp);
    endtask

    initial
    begin
        int phase;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. First the reset configuration, 32-bit with pad.
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b1);
        queue_pixel(32'h1234_5678, 1'b0);
        wait_drained();

        // 24-bit mode; an alpha-only pixel must come out as zeros.
        write_reg(CFG_DEPTH_MODE, {2'b00, MODE_BGR});
        queue_pixel(32'hFF00_0000, 1'b0);
        queue_pixel(32'h00A5_C3E1, 1'b1);
        wait_drained();

        // Packed mode with the reset 5:6:5 layout.
        write_reg(CFG_DEPTH_MODE, {2'b00, MODE_PACKED});
        queue_pixel(32'h00FF_FFFF, 1'b0);
        queue_pixel(32'h00F8_0000, 1'b1);
        queue_pixel(32'h0084_0821, 1'b0);
        wait_drained();

        // Red dropped by a zero size, green above eight bits, blue pushed
        // past the top of the word.
        write_layout(4'd0, 4'd15, 4'd15, 4'd0, 4'd8, 4'd12);
        queue_pixel(32'h00FF_FFFF, 1'b0);
        queue_pixel(32'h0012_3456, 1'b1);
        queue_pixel(32'h0080_0001, 1'b0);
        wait_drained();

        // All three fields on top of each other.
        write_layout(4'd8, 4'd0, 4'd8, 4'd0, 4'd8, 4'd0);
        queue_pixel(32'h0011_2244, 1'b0);
        queue_pixel(32'h00F0_0F55, 1'b1);
        wait_drained();

        // A write to the unused index must leave everything as it was.
        write_reg(CFG_UNUSED, 4'hF);
        queue_pixel(32'h0081_4227, 1'b1);
        wait_drained();

        // Luma: full white must not wrap, single channels show each weight.
        write_reg(CFG_DEPTH_MODE, {2'b11, MODE_LUMA});
        queue_pixel(32'h00FF_FFFF, 1'b1);
        queue_pixel(32'h0000_0000, 1'b0);
        queue_pixel(32'hFF01_0203, 1'b0);
        queue_pixel(32'h00FF_0000, 1'b0);
        queue_pixel(32'h0000_FF00, 1'b0);
        queue_pixel(32'h0000_00FF, 1'b1);
        wait_drained();

        // Random part: twelve phases, each with a fresh configuration.
        for (phase = 0; phase < 12; phase++)
        begin
            if (phase == 1)
            begin
                write_reg(CFG_DEPTH_MODE, {2'b01, MODE_PACKED});
                write_layout(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
            end
            else if (phase == 2)
            begin
                write_reg(CFG_DEPTH_MODE, {2'b10, MODE_PACKED});
                write_layout(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_DEPTH_MODE, {2'(($urandom_range(0, 3))), MODE_PACKED});
                else
                    write_reg(CFG_DEPTH_MODE, 4'($urandom_range(0, 15)));
                write_layout(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
            end

            // One phase runs flat out on both sides.
            no_gaps = (phase == 4);

            if (phase == 3)
            begin
                // Receiver holds off while the sender keeps pushing, so the
                // internal queue fills and in_ready has to drop.
                write_reg(CFG_DEPTH_MODE, {2'b00, MODE_BGRX});
                stall_orders++;
                queue_random_pixels(35);
            end
            else if (phase == 7)
            begin
                // Sender stops halfway and waits for every byte to return.
                queue_random_pixels(17);
                wait_drained();
                queue_random_pixels(18);
            end
            else
            begin
                queue_random_pixels(35);
            end
            wait_drained();
        end
        no_gaps = 1'b0;

        // Any stray byte would show up in the monitor during this wait.
        repeat (20) @(posedge clk);
        if (mismatches == 0 && fb_expect.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
